>>> hw/rtl/kcso_pkg.sv
// Shared types and constants for the keyed continuation seal/open core.
// Used by every RTL file of the block; depends on nothing.
`default_nettype none

package kcso_pkg;

    // Finalizer constants
    localparam logic [63:0] GOLDEN_ADD = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL_B  = 64'h94D049BB133111EB;
    localparam logic [63:0] MASK_SALT  = 64'h434F4E54494E5545;
    localparam logic [63:0] PROOF_SALT = 64'h50524F4F4656514D;

    // Mix pipeline depth and the mask warm-up it implies
    localparam int unsigned MIX_LAT   = 5;
    localparam int unsigned MASK_WAIT = MIX_LAT + 1;
    localparam int unsigned MW_W      = $clog2(MASK_WAIT + 1);

    // Front-to-back job queue
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    // Stream payload widths
    localparam int unsigned S_DATA_W = 160;
    localparam int unsigned M_DATA_W = 160;

    typedef enum logic {
        MODE_SEAL = 1'b0,
        MODE_OPEN = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OOB      = 2'd1,
        ST_MISMATCH = 2'd2
    } t_status;

    // One classified item on its way to the proof unit
    typedef struct packed {
        t_mode       mode;
        logic        oob;    // open: decoded upper half nonzero
        logic [31:0] off;    // seal: offset, open: decoded low half
        logic [63:0] lane;   // seal: masked lane, open: lane as received
        logic [63:0] proof;  // open: proof to check
    } t_job;

endpackage

`default_nettype wire

>>> hw/rtl/kcso_mix.sv
// Five-stage pipelined 64-bit mix finalizer with a job tag riding alongside.
// Depends on kcso_pkg. Each 64x64 multiply is split into 32x32 partials.
`default_nettype none

module kcso_mix (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [63:0]   i_v,
    input  wire kcso_pkg::t_job i_tag,
    output logic               o_valid,
    output logic [63:0]        o_v,
    output kcso_pkg::t_job     o_tag
);
    import kcso_pkg::*;

    logic [MIX_LAT-1:0] r_vld;
    t_job               r_tag [MIX_LAT];

    logic [63:0] r_x1, r_x2, r_out;
    logic [63:0] r_pa_ll, r_pb_ll;
    logic [31:0] r_pa_hl, r_pa_lh, r_pb_hl, r_pb_lh;

    logic [63:0] w_v1, w_x1, w_y, w_x2, w_z;
    logic [63:0] w_pa_ll, w_pb_ll;
    logic [31:0] w_pa_hl, w_pa_lh, w_pb_hl, w_pb_lh;

    // stage 1: add golden constant, xor-shift 30
    assign w_v1 = i_v + GOLDEN_ADD;
    assign w_x1 = w_v1 ^ (w_v1 >> 30);

    // stage 2: partial products by A (cross terms only need low 32 bits)
    assign w_pa_ll = {32'h0, r_x1[31:0]} * {32'h0, MIX_MUL_A[31:0]};
    assign w_pa_hl = r_x1[63:32] * MIX_MUL_A[31:0];
    assign w_pa_lh = r_x1[31:0] * MIX_MUL_A[63:32];

    // stage 3: combine, xor-shift 27
    assign w_y  = r_pa_ll + {r_pa_hl + r_pa_lh, 32'h0};
    assign w_x2 = w_y ^ (w_y >> 27);

    // stage 4: partial products by B
    assign w_pb_ll = {32'h0, r_x2[31:0]} * {32'h0, MIX_MUL_B[31:0]};
    assign w_pb_hl = r_x2[63:32] * MIX_MUL_B[31:0];
    assign w_pb_lh = r_x2[31:0] * MIX_MUL_B[63:32];

    // stage 5: combine, xor-shift 31
    assign w_z = r_pb_ll + {r_pb_hl + r_pb_lh, 32'h0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[MIX_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1    <= w_x1;
            r_pa_ll <= w_pa_ll;
            r_pa_hl <= w_pa_hl;
            r_pa_lh <= w_pa_lh;
            r_x2    <= w_x2;
            r_pb_ll <= w_pb_ll;
            r_pb_hl <= w_pb_hl;
            r_pb_lh <= w_pb_lh;
            r_out   <= w_z ^ (w_z >> 31);
            r_tag[0] <= i_tag;
            for (int i = 1; i < MIX_LAT; i++) begin
                r_tag[i] <= r_tag[i-1];
            end
        end
    end

    assign o_valid = r_vld[MIX_LAT-1];
    assign o_v     = r_out;
    assign o_tag   = r_tag[MIX_LAT-1];

endmodule

`default_nettype wire

>>> hw/rtl/kcso_front.sv
// Front end: key register, mask unit, input classification and job queue.
// Depends on kcso_pkg and kcso_mix.
`default_nettype none

module kcso_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [63:0]                     i_cfg_wdata,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [kcso_pkg::S_DATA_W-1:0]   i_s_tdata,
    input  wire logic [0:0]                      i_s_tuser,
    input  wire logic                            i_pop,
    output logic [63:0]                          o_key,
    output logic                                 o_job_valid,
    output kcso_pkg::t_job                       o_job
);
    import kcso_pkg::*;

    logic [63:0]   r_key;
    logic [63:0]   r_mask;
    logic [MW_W-1:0] r_mask_cnt;
    logic [63:0]   w_mask_v;
    t_job          w_zero_tag;

    t_job          r_q [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;

    t_job          w_job;
    logic [63:0]   w_dec;
    logic          w_full, w_push;

    // key register; any write restarts the mask computation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key      <= '0;
            r_mask_cnt <= MW_W'(MASK_WAIT);
        end else if (i_cfg_we) begin
            r_key      <= i_cfg_wdata;
            r_mask_cnt <= MW_W'(MASK_WAIT);
        end else if (r_mask_cnt != '0) begin
            r_mask_cnt <= r_mask_cnt - 1'b1;
        end
    end

    // mask unit runs freely on the key; sampled once the key has flushed through
    assign w_zero_tag = '0;

    kcso_mix u_mask_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (1'b1),
        .i_valid (1'b1),
        .i_v     (r_key ^ MASK_SALT),
        .i_tag   (w_zero_tag),
        .o_valid (),
        .o_v     (w_mask_v),
        .o_tag   ()
    );

    always_ff @(posedge i_clk) begin
        if (r_mask_cnt == MW_W'(1)) begin
            r_mask <= w_mask_v;
        end
    end

    // classify
    assign w_dec = i_s_tdata[95:32] ^ r_mask;

    always_comb begin
        w_job.mode  = t_mode'(i_s_tuser[0]);
        w_job.proof = i_s_tdata[159:96];
        if (w_job.mode == MODE_SEAL) begin
            w_job.oob  = 1'b0;
            w_job.off  = i_s_tdata[31:0];
            w_job.lane = {32'h0, i_s_tdata[31:0]} ^ r_mask;
        end else begin
            w_job.oob  = |w_dec[63:32];
            w_job.off  = w_dec[31:0];
            w_job.lane = i_s_tdata[95:32];
        end
    end

    // job queue
    assign w_full      = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_s_tready  = (r_mask_cnt == '0) && !w_full;
    assign w_push      = i_s_tvalid && o_s_tready;
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_q[r_rp];
    assign o_key       = r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({w_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
    end

    // a key write holds off input until the new mask is in place
    a_cfg_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_s_tready)
        else $error("input accepted before mask recompute");

    // the back end never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !i_pop)
        else $error("job queue underflow");

    // fill count stays within the queue
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (Q_AW+1)'(Q_DEPTH))
        else $error("job queue overflow");

endmodule

`default_nettype wire

>>> hw/rtl/kcso_back.sv
// Back end: proof mix pipeline and the registered result stage.
// Depends on kcso_pkg and kcso_mix.
`default_nettype none

module kcso_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [63:0]                     i_key,
    input  wire logic                            i_job_valid,
    input  wire kcso_pkg::t_job                  i_job,
    output logic                                 o_pop,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [kcso_pkg::M_DATA_W-1:0]        o_m_tdata,
    output logic [1:0]                           o_m_tuser
);
    import kcso_pkg::*;

    logic        w_en;
    logic        w_mix_vld;
    logic [63:0] w_mix_v;
    t_job        w_tag;

    logic        r_out_vld;
    logic [63:0] r_lane, r_proof;
    logic [31:0] r_off;
    t_status     r_status;

    logic [63:0] n_lane, n_proof;
    logic [31:0] n_off;
    t_status     n_status;

    // whole pipeline advances whenever the result register can take a value
    assign w_en  = !r_out_vld || i_m_tready;
    assign o_pop = w_en && i_job_valid;

    kcso_mix u_proof_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_job_valid),
        .i_v     (i_key ^ {i_job.off, 32'h0} ^ i_job.lane ^ PROOF_SALT),
        .i_tag   (i_job),
        .o_valid (w_mix_vld),
        .o_v     (w_mix_v),
        .o_tag   (w_tag)
    );

    always_comb begin
        n_lane   = '0;
        n_proof  = '0;
        n_off    = '0;
        n_status = ST_OK;
        unique case (w_tag.mode)
            MODE_SEAL: begin
                n_lane  = w_tag.lane;
                n_proof = w_mix_v;
            end
            MODE_OPEN: begin
                if (w_tag.oob) begin
                    n_status = ST_OOB;
                end else begin
                    n_off = w_tag.off;
                    if (w_mix_v != w_tag.proof) begin
                        n_status = ST_MISMATCH;
                    end
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_mix_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lane   <= n_lane;
            r_proof  <= n_proof;
            r_off    <= n_off;
            r_status <= n_status;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_off, r_proof, r_lane};
    assign o_m_tuser  = r_status;

endmodule

`default_nettype wire

>>> hw/rtl/keyed_continuation_seal_open_core.sv
// Keyed continuation seal/open core: top level.
// Depends on kcso_pkg, kcso_front, kcso_back (and kcso_mix below them).
//
// Seals 32-bit code offsets under a 64-bit key and opens sealed lane/proof
// pairs. A seal transfer (tuser = 0) returns lane = offset ^ mask and
// proof = mix(key ^ offset<<32 ^ lane ^ salt); an open transfer (tuser = 1)
// returns the decoded offset with status ok, out of domain (offset forced to
// 0) or proof mismatch. mask = mix(key ^ salt) is kept in a register, so the
// per-item work is one 5-stage mix pipeline. Throughput is one transfer per
// cycle while the result stream is not stalled; a result passes through a
// queue slot, the five mix stages and the result register. A 4-entry queue
// separates the input side from the proof pipeline, so input keeps flowing
// while a result waits, until the queue is full. After reset and after every
// key write, s_axis_tready stays low while the mask unit recomputes the
// mask. Write the key only while no transfer is in flight.
`default_nettype none

module keyed_continuation_seal_open_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // key register
    input  wire logic                            i_cfg_we,
    input  wire logic [63:0]                     i_cfg_wdata,
    // input stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [31:0] code_offset, [95:32] sealed_lane, [159:96] sealed_proof
    input  wire logic [kcso_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // [0] mode
    input  wire logic [0:0]                      s_axis_tuser,
    // result stream
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [63:0] out_lane, [127:64] out_proof, [159:128] opened_offset
    output logic [kcso_pkg::M_DATA_W-1:0]        m_axis_tdata,
    // [1:0] status
    output logic [1:0]                           m_axis_tuser
);
    import kcso_pkg::*;

    logic [63:0] w_key;
    logic        w_job_valid;
    logic        w_pop;
    t_job        w_job;

    // front: key, mask, classify, queue
    kcso_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (s_axis_tvalid),
        .o_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_pop       (w_pop),
        .o_key       (w_key),
        .o_job_valid (w_job_valid),
        .o_job       (w_job)
    );

    // back: proof pipeline and result register
    kcso_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (w_key),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_pop       (w_pop),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser)
    );

endmodule

`default_nettype wire
